### src/epoch_seconds_to_utc_calendar_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the epoch to calendar block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_UTC_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_UTC_CALENDAR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define ESUC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ESUC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/esuc_pkg.sv
// ----------------------------------------------------------------------------
// esuc_pkg
// Widths, calendar constants and stage latencies of the epoch to calendar block.
// ----------------------------------------------------------------------------
`default_nettype none

package esuc_pkg;

    // Field widths
    localparam int SECS_W    = 38;
    localparam int NS_W      = 30;
    localparam int YEAR_W    = 13;
    localparam int YDAY_W    = 9;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;

    // Internal widths
    localparam int DAYS_W    = 22;   // days since the epoch, and the shifted day count
    localparam int DREM_W    = 17;   // seconds within the day
    localparam int MTOT_W    = 11;   // minutes within the day
    localparam int ERA_W     = 5;
    localparam int DOE_W     = 18;   // day of the 400-year era
    localparam int YOE_W     = 9;    // year of the era
    localparam int C100_W    = 2;    // centuries within the era
    localparam int YMOD_W    = 7;    // year of the era modulo 100
    localparam int CYEAR_W   = 14;   // full calendar year

    // Input limits
    localparam logic [SECS_W-1:0] MAX_EPOCH_SECONDS = 38'd253402300799;
    localparam logic [NS_W-1:0]   MAX_NANOSECONDS   = 30'd999999999;

    // 86400 = 675 << 7
    localparam int                DAY_SHIFT       = 7;
    localparam longint unsigned   DAY_DIV_ODD     = 675;
    localparam longint unsigned   SECS_PER_MIN    = 60;
    localparam longint unsigned   MINS_PER_HOUR   = 60;

    // Civil calendar, days counted from 0000-03-01
    localparam logic [DAYS_W-1:0] DAYS_TO_EPOCH   = 22'd719468;
    localparam longint unsigned   DAYS_PER_ERA    = 146097;
    localparam longint unsigned   DAYS_PER_4Y     = 1460;
    localparam longint unsigned   DAYS_PER_100Y   = 36524;
    localparam longint unsigned   DAYS_ERA_LAST   = 146096;
    localparam longint unsigned   DAYS_PER_YEAR   = 365;
    localparam longint unsigned   YEARS_PER_CENT  = 100;
    localparam logic [CYEAR_W-1:0] YEARS_PER_ERA  = 14'd400;
    localparam logic [YDAY_W-1:0] MAR_TO_JAN      = 9'd306;
    localparam logic [YDAY_W-1:0] JAN_OFFSET      = 9'd60;   // Jan/Feb ahead, plus one-based
    localparam logic [YDAY_W-1:0] JAN_NEXT_OFFSET = 9'd305;  // 306 less one-based
    localparam logic [CYEAR_W-1:0] BASE_YEAR      = 14'd1900;

    // Stage latencies
    localparam int DIV_LAT   = 3;
    localparam int CLK_LAT   = 2 * DIV_LAT;
    localparam int CIV_LAT   = 5 * DIV_LAT + 1;
    localparam int PIPE_LAT  = DIV_LAT + CIV_LAT;

endpackage

`default_nettype wire

### src/esuc_cdiv.sv
// ----------------------------------------------------------------------------
// esuc_cdiv
// Three-stage divider by a constant: reciprocal multiply, multiply back and
// subtract, then one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module esuc_cdiv #(
    parameter int              X_W     = 8,
    parameter int              Q_W     = 8,
    parameter longint unsigned DIVISOR = 3,
    localparam int             R_W     = $clog2(DIVISOR)
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [X_W-1:0] x,
    output logic      [Q_W-1:0] quot,
    output logic      [R_W-1:0] rem
);

    // Floor reciprocal: the estimate is low by at most one for any x < 2**X_W
    localparam longint unsigned RECIP = (64'd1 << X_W) / DIVISOR;
    localparam int              M_W   = $clog2(RECIP + 1);
    localparam int              P_W   = X_W + M_W;
    localparam int              R0_W  = R_W + 1;

    logic [P_W-1:0]  prod_reg, prod_next;
    logic [X_W-1:0]  x1_reg;
    logic [Q_W-1:0]  q0_reg, q0_next;
    logic [X_W-1:0]  back_prod;
    logic [R0_W-1:0] r0_reg, r0_next;
    logic [Q_W-1:0]  quot_reg, quot_next;
    logic [R_W-1:0]  rem_reg, rem_next;

    always_comb
    begin
        prod_next = P_W'(x) * P_W'(RECIP);
        q0_next   = Q_W'(prod_reg >> X_W);
        back_prod = X_W'(q0_next) * X_W'(DIVISOR);
        r0_next   = R0_W'(x1_reg - back_prod);
        if (r0_reg >= R0_W'(DIVISOR))
        begin
            quot_next = q0_reg + 1'b1;
            rem_next  = R_W'(r0_reg - R0_W'(DIVISOR));
        end
        else
        begin
            quot_next = q0_reg;
            rem_next  = R_W'(r0_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            x1_reg   <= x;
            q0_reg   <= q0_next;
            r0_reg   <= r0_next;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

### src/esuc_delay.sv
// ----------------------------------------------------------------------------
// esuc_delay
// Shift line that carries side data alongside the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module esuc_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] din,
    output logic      [W-1:0] dout
);

    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

`default_nettype wire

### src/esuc_clock.sv
// ----------------------------------------------------------------------------
// esuc_clock
// Splits the seconds of the day into hour, minute and second.
// ----------------------------------------------------------------------------
`default_nettype none

module esuc_clock (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [esuc_pkg::DREM_W-1:0]  day_secs,
    output logic      [esuc_pkg::HOUR_W-1:0]  hour,
    output logic      [esuc_pkg::MIN_W-1:0]   minute,
    output logic      [esuc_pkg::SEC_W-1:0]   second
);

    import esuc_pkg::*;

    logic [MTOT_W-1:0] min_total;
    logic [SEC_W-1:0]  sec_early;

    esuc_cdiv #(
        .X_W     (DREM_W),
        .Q_W     (MTOT_W),
        .DIVISOR (SECS_PER_MIN)
    ) u_div_min (
        .clk  (clk),
        .en   (en),
        .x    (day_secs),
        .quot (min_total),
        .rem  (sec_early)
    );

    esuc_cdiv #(
        .X_W     (MTOT_W),
        .Q_W     (HOUR_W),
        .DIVISOR (MINS_PER_HOUR)
    ) u_div_hour (
        .clk  (clk),
        .en   (en),
        .x    (min_total),
        .quot (hour),
        .rem  (minute)
    );

    // hold the seconds until the hour split catches up
    esuc_delay #(
        .W     (SEC_W),
        .DEPTH (DIV_LAT)
    ) u_sec_dly (
        .clk  (clk),
        .en   (en),
        .din  (sec_early),
        .dout (second)
    );

endmodule

`default_nettype wire

### src/esuc_civil.sv
// ----------------------------------------------------------------------------
// esuc_civil
// Days since the epoch to year since 1900 and day of year, Gregorian rules.
// ----------------------------------------------------------------------------
`default_nettype none

module esuc_civil (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [esuc_pkg::DAYS_W-1:0]  days,
    output logic      [esuc_pkg::YEAR_W-1:0]  year_since_1900,
    output logic      [esuc_pkg::YDAY_W-1:0]  day_of_year
);

    import esuc_pkg::*;

    logic [DAYS_W-1:0]  z_reg, z_next;
    logic [ERA_W-1:0]   era;
    logic [DOE_W-1:0]   doe;
    logic [7-1:0]       n4y;
    logic [3-1:0]       n100y;
    logic               n400y;
    logic [DOE_W-1:0]   doe_d3;
    logic [DOE_W-1:0]   doe_d10;
    logic [ERA_W-1:0]   era_d10;
    logic [DOE_W-1:0]   t_reg, t_next;
    logic [YOE_W-1:0]   yoe;
    logic [YOE_W-1:0]   yoe_d3;
    logic [C100_W-1:0]  cent;
    logic [YMOD_W-1:0]  yoe_mod100;
    logic [DOE_W-1:0]   yoe_days;
    logic [YDAY_W-1:0]  doy_reg, doy_next;
    logic [CYEAR_W-1:0] y_reg, y_next;
    logic               leap_reg, leap_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [YDAY_W-1:0]  yday_reg, yday_next;

    // Count from 0000-03-01 so the leap day closes each year
    assign z_next = days + DAYS_TO_EPOCH;

    esuc_cdiv #(
        .X_W     (DAYS_W),
        .Q_W     (ERA_W),
        .DIVISOR (DAYS_PER_ERA)
    ) u_div_era (
        .clk  (clk),
        .en   (en),
        .x    (z_reg),
        .quot (era),
        .rem  (doe)
    );

    esuc_cdiv #(
        .X_W     (DOE_W),
        .Q_W     (7),
        .DIVISOR (DAYS_PER_4Y)
    ) u_div_4y (
        .clk  (clk),
        .en   (en),
        .x    (doe),
        .quot (n4y),
        .rem  ()
    );

    esuc_cdiv #(
        .X_W     (DOE_W),
        .Q_W     (3),
        .DIVISOR (DAYS_PER_100Y)
    ) u_div_100y (
        .clk  (clk),
        .en   (en),
        .x    (doe),
        .quot (n100y),
        .rem  ()
    );

    esuc_cdiv #(
        .X_W     (DOE_W),
        .Q_W     (1),
        .DIVISOR (DAYS_ERA_LAST)
    ) u_div_400y (
        .clk  (clk),
        .en   (en),
        .x    (doe),
        .quot (n400y),
        .rem  ()
    );

    esuc_delay #(
        .W     (DOE_W),
        .DEPTH (DIV_LAT)
    ) u_doe_dly_a (
        .clk  (clk),
        .en   (en),
        .din  (doe),
        .dout (doe_d3)
    );

    esuc_delay #(
        .W     (DOE_W),
        .DEPTH (2 * DIV_LAT + 1)
    ) u_doe_dly_b (
        .clk  (clk),
        .en   (en),
        .din  (doe_d3),
        .dout (doe_d10)
    );

    esuc_delay #(
        .W     (ERA_W),
        .DEPTH (3 * DIV_LAT + 1)
    ) u_era_dly (
        .clk  (clk),
        .en   (en),
        .din  (era),
        .dout (era_d10)
    );

    // Drop the leap days so a plain divide by 365 gives the year of the era
    assign t_next = doe_d3 - DOE_W'(n4y) + DOE_W'(n100y) - DOE_W'(n400y);

    esuc_cdiv #(
        .X_W     (DOE_W),
        .Q_W     (YOE_W),
        .DIVISOR (DAYS_PER_YEAR)
    ) u_div_yoe (
        .clk  (clk),
        .en   (en),
        .x    (t_reg),
        .quot (yoe),
        .rem  ()
    );

    esuc_cdiv #(
        .X_W     (YOE_W),
        .Q_W     (C100_W),
        .DIVISOR (YEARS_PER_CENT)
    ) u_div_cent (
        .clk  (clk),
        .en   (en),
        .x    (yoe),
        .quot (cent),
        .rem  (yoe_mod100)
    );

    esuc_delay #(
        .W     (YOE_W),
        .DEPTH (DIV_LAT)
    ) u_yoe_dly (
        .clk  (clk),
        .en   (en),
        .din  (yoe),
        .dout (yoe_d3)
    );

    always_comb
    begin
        yoe_days  = DOE_W'(yoe_d3) * DOE_W'(DAYS_PER_YEAR)
                    + DOE_W'(yoe_d3 >> 2) - DOE_W'(cent);
        doy_next  = YDAY_W'(doe_d10 - yoe_days);
        y_next    = CYEAR_W'(yoe_d3) + CYEAR_W'(era_d10) * YEARS_PER_ERA;
        // The era starts on a multiple of 400, so the year of the era decides leap
        leap_next = ((yoe_d3[1:0] == 2'b00) && (yoe_mod100 != '0)) || (yoe_d3 == '0);

        if (doy_reg >= MAR_TO_JAN)
        begin
            year_next = YEAR_W'(y_reg + 1'b1 - BASE_YEAR);
            yday_next = doy_reg - JAN_NEXT_OFFSET;
        end
        else
        begin
            year_next = YEAR_W'(y_reg - BASE_YEAR);
            yday_next = doy_reg + JAN_OFFSET + YDAY_W'(leap_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg    <= z_next;
            t_reg    <= t_next;
            doy_reg  <= doy_next;
            y_reg    <= y_next;
            leap_reg <= leap_next;
            year_reg <= year_next;
            yday_reg <= yday_next;
        end
    end

    assign year_since_1900 = year_reg;
    assign day_of_year     = yday_reg;

endmodule

`default_nettype wire

### src/epoch_seconds_to_utc_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar
// POSIX epoch seconds and nanoseconds to UTC year, day of year and time of day.
// ----------------------------------------------------------------------------
// Input channel: epoch_valid / epoch_stall carry epoch_seconds and nanoseconds.
// Output channel: cal_valid / cal_stall carry the calendar fields, the
// nanoseconds passed through, and out_of_range.
// An item moves at a rising edge where valid is high and stall is low.
// Throughput: one item per cycle, sustained, for as long as cal_stall is low.
// Pipeline: 20 register stages, the first loaded by the edge that accepts an
// item: 3 stages for the day split, 16 for the calendar chain of constant
// dividers and correction steps, and the output register.
// Seconds past 9999-12-31 23:59:59 or nanoseconds above 999999999 give a result
// with out_of_range set and every other field zero.
// Reset empties the pipeline and the output; nothing else is kept.
// When the receiver stalls, the output register holds its item and one more
// item lands in a skid register; epoch_stall then rises and the whole pipeline
// holds until the skid register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_utc_calendar (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         epoch_valid,
    output logic                              epoch_stall,
    input  wire logic [esuc_pkg::SECS_W-1:0]  epoch_seconds,
    input  wire logic [esuc_pkg::NS_W-1:0]    nanoseconds,
    output logic                              cal_valid,
    input  wire logic                         cal_stall,
    output logic      [esuc_pkg::YEAR_W-1:0]  year_since_1900,
    output logic      [esuc_pkg::YDAY_W-1:0]  day_of_year,
    output logic      [esuc_pkg::HOUR_W-1:0]  hour_of_day,
    output logic      [esuc_pkg::MIN_W-1:0]   minute_of_hour,
    output logic      [esuc_pkg::SEC_W-1:0]   second_of_minute,
    output logic      [esuc_pkg::NS_W-1:0]    fraction_ns,
    output logic                              out_of_range
);

    import esuc_pkg::*;

    `include "epoch_seconds_to_utc_calendar_assert.svh"

    localparam int HMS_W = HOUR_W + MIN_W + SEC_W;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [YDAY_W-1:0] yday;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [NS_W-1:0]   ns;
        logic              oor;
    } result_t;

    logic                  pipe_en;
    logic                  oor_in;
    logic [PIPE_LAT-1:0]   valid_pipe_reg;
    logic [DAYS_W-1:0]     days;
    logic [$clog2(DAY_DIV_ODD)-1:0] day_rem_hi;
    logic [DAY_SHIFT-1:0]  secs_lo;
    logic [DREM_W-1:0]     day_secs;
    logic [HOUR_W-1:0]     hour_early;
    logic [MIN_W-1:0]      minute_early;
    logic [SEC_W-1:0]      second_early;
    logic [HMS_W-1:0]      hms;
    logic [YEAR_W-1:0]     year_late;
    logic [YDAY_W-1:0]     yday_late;
    logic [NS_W-1:0]       ns_late;
    logic                  oor_late;
    result_t               pipe_res;
    result_t               cal_reg, cal_next;
    result_t               skid_reg, skid_next;
    logic                  cal_valid_reg, cal_valid_next;
    logic                  skid_full_reg, skid_full_next;

    assign pipe_en     = !skid_full_reg;
    assign epoch_stall = skid_full_reg;
    assign oor_in      = (epoch_seconds > MAX_EPOCH_SECONDS) || (nanoseconds > MAX_NANOSECONDS);

    // 86400 = 675 << 7: divide the shifted seconds by 675, keep the low bits
    esuc_cdiv #(
        .X_W     (SECS_W - DAY_SHIFT),
        .Q_W     (DAYS_W),
        .DIVISOR (DAY_DIV_ODD)
    ) u_div_day (
        .clk  (clk),
        .en   (pipe_en),
        .x    (epoch_seconds[SECS_W-1:DAY_SHIFT]),
        .quot (days),
        .rem  (day_rem_hi)
    );

    esuc_delay #(
        .W     (DAY_SHIFT),
        .DEPTH (DIV_LAT)
    ) u_lo_dly (
        .clk  (clk),
        .en   (pipe_en),
        .din  (epoch_seconds[DAY_SHIFT-1:0]),
        .dout (secs_lo)
    );

    assign day_secs = {day_rem_hi, secs_lo};

    esuc_clock u_clock (
        .clk      (clk),
        .en       (pipe_en),
        .day_secs (day_secs),
        .hour     (hour_early),
        .minute   (minute_early),
        .second   (second_early)
    );

    esuc_delay #(
        .W     (HMS_W),
        .DEPTH (CIV_LAT - CLK_LAT)
    ) u_hms_dly (
        .clk  (clk),
        .en   (pipe_en),
        .din  ({hour_early, minute_early, second_early}),
        .dout (hms)
    );

    esuc_civil u_civil (
        .clk             (clk),
        .en              (pipe_en),
        .days            (days),
        .year_since_1900 (year_late),
        .day_of_year     (yday_late)
    );

    esuc_delay #(
        .W     (NS_W + 1),
        .DEPTH (PIPE_LAT)
    ) u_side_dly (
        .clk  (clk),
        .en   (pipe_en),
        .din  ({nanoseconds, oor_in}),
        .dout ({ns_late, oor_late})
    );

    always_comb
    begin
        pipe_res.oor    = oor_late;
        pipe_res.year   = oor_late ? '0 : year_late;
        pipe_res.yday   = oor_late ? '0 : yday_late;
        pipe_res.hour   = oor_late ? '0 : hms[HMS_W-1 -: HOUR_W];
        pipe_res.minute = oor_late ? '0 : hms[SEC_W +: MIN_W];
        pipe_res.second = oor_late ? '0 : hms[SEC_W-1:0];
        pipe_res.ns     = oor_late ? '0 : ns_late;
    end

    // Output register plus one skid entry
    always_comb
    begin
        cal_next       = cal_reg;
        cal_valid_next = cal_valid_reg;
        skid_next      = skid_reg;
        skid_full_next = skid_full_reg;
        priority if (cal_valid_reg && cal_stall)
        begin
            if (pipe_en && valid_pipe_reg[PIPE_LAT-1])
            begin
                skid_next      = pipe_res;
                skid_full_next = 1'b1;
            end
        end
        else if (skid_full_reg)
        begin
            cal_next       = skid_reg;
            cal_valid_next = 1'b1;
            skid_full_next = 1'b0;
        end
        else
        begin
            cal_next       = pipe_res;
            cal_valid_next = valid_pipe_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
            cal_valid_reg  <= 1'b0;
            skid_full_reg  <= 1'b0;
        end
        else
        begin
            if (pipe_en)
            begin
                valid_pipe_reg <= {valid_pipe_reg[PIPE_LAT-2:0], epoch_valid};
            end
            cal_valid_reg <= cal_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cal_reg  <= cal_next;
        skid_reg <= skid_next;
    end

    assign cal_valid        = cal_valid_reg;
    assign year_since_1900  = cal_reg.year;
    assign day_of_year      = cal_reg.yday;
    assign hour_of_day      = cal_reg.hour;
    assign minute_of_hour   = cal_reg.minute;
    assign second_of_minute = cal_reg.second;
    assign fraction_ns      = cal_reg.ns;
    assign out_of_range     = cal_reg.oor;

    `ESUC_ASSERT_SAME(a_skid_behind_out, skid_full_reg, cal_valid_reg,
        "skid entry filled while output register empty")
    `ESUC_ASSERT_NEXT(a_frozen_pipe_holds, !pipe_en, $stable(valid_pipe_reg),
        "pipeline moved while frozen")
    `ESUC_ASSERT_NEXT(a_skid_drains, skid_full_reg && !cal_stall, !skid_full_reg,
        "skid entry not drained after output taken")
    `ESUC_ASSERT_SAME(a_oor_zeroes, cal_valid_reg && out_of_range,
        year_since_1900 == '0 && day_of_year == '0 && hour_of_day == '0 &&
        minute_of_hour == '0 && second_of_minute == '0 && fraction_ns == '0,
        "out of range item carries nonzero fields")
    `ESUC_ASSERT_SAME(a_fields_bounded, cal_valid_reg && !out_of_range,
        day_of_year != '0 && day_of_year <= 9'd366 && hour_of_day <= 5'd23 &&
        minute_of_hour <= 6'd59 && second_of_minute <= 6'd59,
        "calendar field out of bounds")

endmodule

`default_nettype wire
